// ===== rtl/cau_pkg.sv =====
// Package with the shared widths, codes, types and saturation function of the complex ALU.
package cau_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 8;
  localparam int PW         = 2 * DATA_WIDTH;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_SAT = 2'd1,
    ST_DZ  = 2'd2
  } status_t;

  typedef logic signed [DATA_WIDTH-1:0] data_t;

  typedef struct packed {
    logic  sat;
    data_t val;
  } sat_t;

  // Information that travels alongside an item through the divider.
  typedef struct packed {
    op_t     op;
    logic    re_neg;
    logic    im_neg;
    logic    dz;
    data_t   pre_re;
    data_t   pre_im;
    status_t pre_st;
  } side_t;

  // Clamps a wide signed value to the data range.
  function automatic sat_t sat_fn(input logic signed [PW:0] x);
    sat_t r;
    logic signed [PW:0] hi;
    logic signed [PW:0] lo;
    hi = (PW+1)'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
    lo = -hi - (PW+1)'(1);
    if (x > hi) begin
      r.sat = 1'b1;
      r.val = hi[DATA_WIDTH-1:0];
    end else if (x < lo) begin
      r.sat = 1'b1;
      r.val = lo[DATA_WIDTH-1:0];
    end else begin
      r.sat = 1'b0;
      r.val = x[DATA_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/cau_div.sv =====
// Pipelined restoring divider, two lanes sharing one divisor, one quotient bit per stage.
module cau_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [cau_pkg::PW-1:0]    in_num_re,
  input  logic [cau_pkg::PW-1:0]    in_num_im,
  input  logic [cau_pkg::PW-1:0]    in_den,
  input  cau_pkg::side_t            in_side,
  output logic                      out_valid,
  output logic [cau_pkg::DATA_WIDTH-1:0] out_q_re,
  output logic [cau_pkg::DATA_WIDTH-1:0] out_q_im,
  output logic                      out_ovf_re,
  output logic                      out_ovf_im,
  output cau_pkg::side_t            out_side
);
  import cau_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int XW = PW + DW;

  typedef struct packed {
    logic [PW-1:0] rem;
    logic [DW-1:0] low;
    logic [DW-1:0] q;
    logic          ovf;
  } lane_t;

  logic          v_r    [0:DW];
  logic [PW-1:0] den_r  [0:DW];
  side_t         side_r [0:DW];
  lane_t         re_r   [0:DW];
  lane_t         im_r   [0:DW];

  // The quotient fits the data width only when num < den * 2^(DW-FB).
  function automatic lane_t lane_init(input logic [PW-1:0] num, input logic [PW-1:0] den);
    lane_t l;
    logic [XW-1:0] nsh;
    nsh   = XW'(num) << FRAC_BITS;
    l.ovf = (XW'(num) >= (XW'(den) << (DW - FRAC_BITS)));
    l.rem = nsh[XW-1:DW];
    l.low = nsh[DW-1:0];
    l.q   = '0;
    return l;
  endfunction

  function automatic lane_t lane_step(input lane_t l, input logic [PW-1:0] den);
    lane_t n;
    logic [PW:0] t;
    logic [PW:0] d;
    t     = {l.rem, l.low[DW-1]};
    d     = (PW+1)'(den);
    n     = l;
    n.low = l.low << 1;
    if (t >= d) begin
      n.rem = PW'(t - d);
      n.q   = {l.q[DW-2:0], 1'b1};
    end else begin
      n.rem = t[PW-1:0];
      n.q   = {l.q[DW-2:0], 1'b0};
    end
    return n;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0]  <= in_den;
      side_r[0] <= in_side;
      re_r[0]   <= lane_init(in_num_re, in_den);
      im_r[0]   <= lane_init(in_num_im, in_den);
    end
  end

  for (genvar k = 1; k <= DW; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k]  <= den_r[k-1];
        side_r[k] <= side_r[k-1];
        re_r[k]   <= lane_step(re_r[k-1], den_r[k-1]);
        im_r[k]   <= lane_step(im_r[k-1], den_r[k-1]);
      end
    end
  end

  assign out_valid  = v_r[DW];
  assign out_q_re   = re_r[DW].q;
  assign out_q_im   = im_r[DW].q;
  assign out_ovf_re = re_r[DW].ovf;
  assign out_ovf_im = im_r[DW].ovf;
  assign out_side   = side_r[DW];

endmodule

// ===== rtl/complex_arithmetic_unit_top.sv =====
// Top level of the complex ALU: operand capture, products, sums, divider and output format.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_stall  | func, a_real, a_imag, b_real, b_imag
//   out_    | output    | out_valid / out_stall| res_real, res_imag, status
//
// Every item, whatever its operation, passes through the same registers from the edge that
// accepts it to the first edge at which its result can be taken: operand capture, products,
// the divider, which resolves one quotient bit per stage, and the output register. One item
// can be accepted in every cycle while in_stall is low.
// Reset is synchronous and active low; it clears all stage valid bits.
// A stalled result freezes the whole pipeline, so in_stall follows out_stall while a result
// is waiting; nothing is dropped or repeated.
module complex_arithmetic_unit_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_func,
  input  cau_pkg::data_t        in_a_real,
  input  cau_pkg::data_t        in_a_imag,
  input  cau_pkg::data_t        in_b_real,
  input  cau_pkg::data_t        in_b_imag,
  output logic                  out_valid,
  input  logic                  out_stall,
  output cau_pkg::data_t        out_res_real,
  output cau_pkg::data_t        out_res_imag,
  output logic [1:0]            out_status
);
  import cau_pkg::*;

  localparam int DW = DATA_WIDTH;

  // Output stage valid bit; it decides whether the pipeline may advance.
  logic out_valid_r;

  // Global advance: the pipeline moves unless a finished result is held.
  logic en;
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // Stage 1: operand capture.
  logic  v1_r;
  op_t   op1_r;
  data_t ar1_r, ai1_r, br1_r, bi1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r <= op_t'(in_func);
      ar1_r <= in_a_real;
      ai1_r <= in_a_imag;
      br1_r <= in_b_real;
      bi1_r <= in_b_imag;
    end
  end

  // Stage 2: the six products, plus add and subtract finished and saturated.
  logic                 v2_r;
  op_t                  op2_r;
  logic signed [PW-1:0] ac_r, bd_r, ad_r, bc_r, cc_r, dd_r;
  sat_t                 as_re_r, as_im_r;
  sat_t                 as_re_nxt, as_im_nxt;

  always_comb begin
    logic signed [PW:0] x_re;
    logic signed [PW:0] y_re;
    logic signed [PW:0] x_im;
    logic signed [PW:0] y_im;
    x_re = (PW+1)'(ar1_r);
    y_re = (PW+1)'(br1_r);
    x_im = (PW+1)'(ai1_r);
    y_im = (PW+1)'(bi1_r);
    if (op1_r == OP_SUB) begin
      as_re_nxt = sat_fn(x_re - y_re);
      as_im_nxt = sat_fn(x_im - y_im);
    end else begin
      as_re_nxt = sat_fn(x_re + y_re);
      as_im_nxt = sat_fn(x_im + y_im);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op2_r   <= op1_r;
      ac_r    <= PW'(ar1_r) * PW'(br1_r);
      bd_r    <= PW'(ai1_r) * PW'(bi1_r);
      ad_r    <= PW'(ar1_r) * PW'(bi1_r);
      bc_r    <= PW'(ai1_r) * PW'(br1_r);
      cc_r    <= PW'(br1_r) * PW'(br1_r);
      dd_r    <= PW'(bi1_r) * PW'(bi1_r);
      as_re_r <= as_re_nxt;
      as_im_r <= as_im_nxt;
    end
  end

  // Stage 3 (combinational into the divider input): sums, multiply result, divide operands.
  side_t         side_nxt;
  logic [PW-1:0] num_re_nxt, num_im_nxt, den_nxt;

  always_comb begin
    logic signed [PW:0] m_re;
    logic signed [PW:0] m_im;
    logic signed [PW:0] n_re;
    logic signed [PW:0] n_im;
    logic        [PW:0] den_w;
    sat_t               s_re;
    sat_t               s_im;
    m_re  = (PW+1)'(ac_r) - (PW+1)'(bd_r);
    m_im  = (PW+1)'(ad_r) + (PW+1)'(bc_r);
    n_re  = (PW+1)'(ac_r) + (PW+1)'(bd_r);
    n_im  = (PW+1)'(bc_r) - (PW+1)'(ad_r);
    den_w = (PW+1)'(cc_r) + (PW+1)'(dd_r);
    // The arithmetic shift rounds the product sum toward minus infinity.
    if (op2_r == OP_MUL) begin
      s_re = sat_fn(m_re >>> FRAC_BITS);
      s_im = sat_fn(m_im >>> FRAC_BITS);
    end else begin
      s_re = as_re_r;
      s_im = as_im_r;
    end
    side_nxt.op     = op2_r;
    side_nxt.re_neg = n_re[PW];
    side_nxt.im_neg = n_im[PW];
    side_nxt.dz     = (den_w == '0);
    side_nxt.pre_re = s_re.val;
    side_nxt.pre_im = s_im.val;
    side_nxt.pre_st = (s_re.sat || s_im.sat) ? ST_SAT : ST_OK;
    num_re_nxt      = n_re[PW] ? PW'(-n_re) : n_re[PW-1:0];
    num_im_nxt      = n_im[PW] ? PW'(-n_im) : n_im[PW-1:0];
    den_nxt         = den_w[PW-1:0];
  end

  logic          dv_valid;
  logic [DW-1:0] q_re, q_im;
  logic          ovf_re, ovf_im;
  side_t         dside;

  cau_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (v2_r),
    .in_num_re  (num_re_nxt),
    .in_num_im  (num_im_nxt),
    .in_den     (den_nxt),
    .in_side    (side_nxt),
    .out_valid  (dv_valid),
    .out_q_re   (q_re),
    .out_q_im   (q_im),
    .out_ovf_re (ovf_re),
    .out_ovf_im (ovf_im),
    .out_side   (dside)
  );

  // Applies the sign to a quotient magnitude and saturates it.
  function automatic sat_t sign_sat(input logic [DW-1:0] q, input logic ovf,
                                    input logic neg);
    logic signed [PW:0] m;
    m = (PW+1)'({1'b0, q});
    if (ovf) begin
      m = (PW+1)'(1) <<< DW;
    end
    return sat_fn(neg ? -m : m);
  endfunction

  // Output stage.
  data_t   res_re_r, res_im_r;
  status_t st_r;
  data_t   res_re_nxt, res_im_nxt;
  status_t st_nxt;

  always_comb begin
    sat_t d_re;
    sat_t d_im;
    d_re = sign_sat(q_re, ovf_re, dside.re_neg);
    d_im = sign_sat(q_im, ovf_im, dside.im_neg);
    if (dside.op != OP_DIV) begin
      res_re_nxt = dside.pre_re;
      res_im_nxt = dside.pre_im;
      st_nxt     = dside.pre_st;
    end else if (dside.dz) begin
      res_re_nxt = '0;
      res_im_nxt = '0;
      st_nxt     = ST_DZ;
    end else begin
      res_re_nxt = d_re.val;
      res_im_nxt = d_im.val;
      st_nxt     = (d_re.sat || d_im.sat) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_re_r <= res_re_nxt;
      res_im_r <= res_im_nxt;
      st_r     <= st_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_res_real = res_re_r;
  assign out_res_imag = res_im_r;
  assign out_status   = st_r;

endmodule

// ===== sim/tb.sv =====
// Testbench for the complex arithmetic unit: directed table plus random items, checked by a predictor.
module tb;
  import cau_pkg::*;

  // Sign-magnitude value, wide enough for every exact product and sum.
  typedef struct {
    logic            neg;
    longint unsigned mag;
  } smag_t;

  // One expected result of the unit.
  typedef struct {
    data_t       re;
    data_t       im;
    logic [1:0]  st;
  } cplx_res_t;

  // One row of the directed table. When typed is set, the result is written out
  // by hand; otherwise the predictor supplies it.
  typedef struct {
    op_t        op;
    data_t      ar;
    data_t      ai;
    data_t      br;
    data_t      bi;
    logic       typed;
    data_t      er;
    data_t      ei;
    status_t    est;
  } dir_row_t;

  localparam longint unsigned HALF  = 64'd1 << (DATA_WIDTH - 1);
  localparam longint unsigned QCAP  = 64'd1 << 34;
  localparam int              LATENCY = DATA_WIDTH + 4;
  localparam int              CYCLE_LIMIT = 400000;
  localparam int              RAND_PER_PHASE = 125;

  logic   clk;
  logic   rst_n;
  logic   in_valid;
  logic   in_stall;
  logic [1:0] in_func;
  data_t  in_a_real;
  data_t  in_a_imag;
  data_t  in_b_real;
  data_t  in_b_imag;
  logic   out_valid;
  logic   out_stall;
  data_t  out_res_real;
  data_t  out_res_imag;
  logic [1:0] out_status;

  cplx_res_t expected_results[$];
  int  errors;
  int  cycles;
  int  items_sent;
  int  results_seen;
  int  sat_seen;
  int  dz_seen;
  int  send_idle_pct;
  int  stall_pct;

  complex_arithmetic_unit_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_a_real    (in_a_real),
    .in_a_imag    (in_a_imag),
    .in_b_real    (in_b_real),
    .in_b_imag    (in_b_imag),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_res_real (out_res_real),
    .out_res_imag (out_res_imag),
    .out_status   (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor. All arithmetic is exact in sign-magnitude form, as in the
  // specification of the unit; rounding happens only at the shift or divide.
  // ---------------------------------------------------------------------------
  function automatic smag_t to_smag(data_t v);
    smag_t r;
    r.neg = v[DATA_WIDTH-1];
    r.mag = r.neg ? ((64'd1 << DATA_WIDTH) - longint'(unsigned'(v))) : longint'(unsigned'(v));
    return r;
  endfunction

  function automatic smag_t smag_mul(smag_t x, smag_t y);
    smag_t r;
    r.neg = x.neg ^ y.neg;
    r.mag = x.mag * y.mag;
    return r;
  endfunction

  function automatic smag_t smag_add(smag_t x, smag_t y);
    smag_t r;
    if (x.neg == y.neg) begin
      r.neg = x.neg;
      r.mag = x.mag + y.mag;
    end else if (x.mag >= y.mag) begin
      r.neg = x.neg;
      r.mag = x.mag - y.mag;
    end else begin
      r.neg = y.neg;
      r.mag = y.mag - x.mag;
    end
    return r;
  endfunction

  function automatic smag_t smag_neg(smag_t x);
    x.neg = ~x.neg;
    return x;
  endfunction

  // Arithmetic shift right: negative values round toward minus infinity.
  function automatic smag_t smag_floor_shift(smag_t x);
    if (x.neg) x.mag = (x.mag + ((64'd1 << FRAC_BITS) - 1)) >> FRAC_BITS;
    else x.mag = x.mag >> FRAC_BITS;
    return x;
  endfunction

  // (num << FRAC_BITS) / den with the quotient truncated toward zero and capped.
  function automatic smag_t smag_frac_div(smag_t num, longint unsigned den);
    smag_t r;
    longint unsigned q;
    longint unsigned rem;
    q = num.mag / den;
    rem = num.mag % den;
    if (q > QCAP) q = QCAP;
    for (int i = 0; i < FRAC_BITS; i++) begin
      q = q << 1;
      if (rem >= den - rem) begin
        rem = rem - (den - rem);
        q = q | 64'd1;
      end else begin
        rem = rem << 1;
      end
      if (q > QCAP) q = QCAP;
    end
    r.neg = num.neg;
    r.mag = q;
    return r;
  endfunction

  // Saturates to the data range; a zero magnitude is always plain zero.
  function automatic data_t clamp_part(smag_t v, inout logic sat);
    longint unsigned m;
    m = v.mag;
    if (m == 0) return '0;
    if (v.neg) begin
      if (m > HALF) begin
        m = HALF;
        sat = 1'b1;
      end
      return data_t'(-m);
    end
    if (m > HALF - 1) begin
      m = HALF - 1;
      sat = 1'b1;
    end
    return data_t'(m);
  endfunction

  function automatic cplx_res_t predict_cplx(op_t op, data_t ar, data_t ai, data_t br, data_t bi);
    cplx_res_t r;
    smag_t a;
    smag_t b;
    smag_t c;
    smag_t d;
    smag_t re;
    smag_t im;
    longint unsigned den;
    logic sat;
    a = to_smag(ar);
    b = to_smag(ai);
    c = to_smag(br);
    d = to_smag(bi);
    sat = 1'b0;
    case (op)
      OP_ADD: begin
        re = smag_add(a, c);
        im = smag_add(b, d);
      end
      OP_SUB: begin
        re = smag_add(a, smag_neg(c));
        im = smag_add(b, smag_neg(d));
      end
      OP_MUL: begin
        re = smag_floor_shift(smag_add(smag_mul(a, c), smag_neg(smag_mul(b, d))));
        im = smag_floor_shift(smag_add(smag_mul(a, d), smag_mul(b, c)));
      end
      default: begin
        den = c.mag * c.mag + d.mag * d.mag;
        if (den == 0) begin
          r.re = '0;
          r.im = '0;
          r.st = ST_DZ;
          return r;
        end
        re = smag_frac_div(smag_add(smag_mul(a, c), smag_mul(b, d)), den);
        im = smag_frac_div(smag_add(smag_mul(b, c), smag_neg(smag_mul(a, d))), den);
      end
    endcase
    r.re = clamp_part(re, sat);
    r.im = clamp_part(im, sat);
    r.st = sat ? ST_SAT : ST_OK;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. The task is entered and left at a falling edge; the item is
  // held until the rising edge at which the unit takes it.
  // ---------------------------------------------------------------------------
  task automatic send_item(op_t op, data_t ar, data_t ai, data_t br, data_t bi,
                           cplx_res_t exp_res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_func   <= op;
    in_a_real <= ar;
    in_a_imag <= ai;
    in_b_real <= br;
    in_b_imag <= bi;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(exp_res);
    items_sent++;
    @(negedge clk);
  endtask

  // Operand mix: full random, small values near one, extremes and zero.
  function automatic data_t pick_operand();
    case ($urandom_range(9))
      0:       return data_t'(16'h8000);
      1:       return data_t'(16'h7fff);
      2:       return '0;
      3, 4:    return data_t'($signed($urandom_range(2047)) - 1024);
      default: return data_t'($urandom);
    endcase
  endfunction

  task automatic send_random();
    op_t   op;
    data_t ar;
    data_t ai;
    data_t br;
    data_t bi;
    op = op_t'($urandom_range(3));
    ar = pick_operand();
    ai = pick_operand();
    br = pick_operand();
    bi = pick_operand();
    // Divide by zero has to come up regularly, not just by chance.
    if (op == OP_DIV && $urandom_range(7) == 0) begin
      br = '0;
      bi = '0;
    end
    send_item(op, ar, ai, br, bi, predict_cplx(op, ar, ai, br, bi));
  endtask

  // ---------------------------------------------------------------------------
  // Output side: the stall is redrawn on each falling edge, and results are
  // checked on the rising edge at which they are taken.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cplx_res_t e;
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (out_status == ST_SAT) sat_seen++;
      if (out_status == ST_DZ) dz_seen++;
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: re=%0d im=%0d status=%0d",
               out_res_real, out_res_imag, out_status);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_res_real !== e.re) begin
          $error("res_real: expected %0d, got %0d", e.re, out_res_real);
          errors++;
        end
        if (out_res_imag !== e.im) begin
          $error("res_imag: expected %0d, got %0d", e.im, out_res_imag);
          errors++;
        end
        if (out_status !== e.st) begin
          $error("status: expected %0d, got %0d", e.st, out_status);
          errors++;
        end
      end
    end
  end

  // A hung handshake ends the run here.
  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, expected_results.size());
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table. Rows with a typed result can be read straight off the
  // definition of the unit; the rest lean on the predictor.
  // ---------------------------------------------------------------------------
  dir_row_t dir_rows[20] = '{
    // Zero plus zero.
    '{OP_ADD, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 16'sd0, 16'sd0, ST_OK},
    // Positive overflow on add saturates to the top of the range.
    '{OP_ADD, 16'sh7fff, 16'sd0, 16'sd1, 16'sd0, 1'b1, 16'sh7fff, 16'sd0, ST_SAT},
    // Most negative plus itself saturates to the bottom.
    '{OP_ADD, 16'sh8000, 16'sh8000, 16'sh8000, 16'sd0, 1'b1,
      16'sh8000, 16'sh8000, ST_SAT},
    // Subtract overflow in both directions.
    '{OP_SUB, 16'sh8000, 16'sh7fff, 16'sd1, 16'sh8000, 1'b1,
      16'sh8000, 16'sh7fff, ST_SAT},
    '{OP_SUB, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 1'b1, 16'sd0, 16'sd0, ST_OK},
    // One times one in Q8.8.
    '{OP_MUL, 16'sd256, 16'sd0, 16'sd256, 16'sd0, 1'b1, 16'sd256, 16'sd0, ST_OK},
    // Multiply rounds toward minus infinity: the smallest negative product is -1 LSB.
    '{OP_MUL, 16'sd1, 16'sd0, -16'sd1, 16'sd0, 1'b1, -16'sd1, 16'sd0, ST_OK},
    // The product of two most negative values overflows.
    '{OP_MUL, 16'sh8000, 16'sd0, 16'sh8000, 16'sd0, 1'b1, 16'sh7fff, 16'sd0, ST_SAT},
    '{OP_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0, 16'sd0, 16'sd0, ST_OK},
    '{OP_MUL, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff, 1'b0, 16'sd0, 16'sd0, ST_OK},
    '{OP_MUL, 16'sd384, -16'sd640, -16'sd77, 16'sd999, 1'b0, 16'sd0, 16'sd0, ST_OK},
    // Divide by zero gives zero parts and its own status.
    '{OP_DIV, 16'sh7fff, 16'sh8000, 16'sd0, 16'sd0, 1'b1, 16'sd0, 16'sd0, ST_DZ},
    '{OP_DIV, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 16'sd0, 16'sd0, ST_DZ},
    // One divided by one.
    '{OP_DIV, 16'sd256, 16'sd0, 16'sd256, 16'sd0, 1'b1, 16'sd256, 16'sd0, ST_OK},
    // A huge value over the smallest divisor saturates.
    '{OP_DIV, 16'sh7fff, 16'sh8000, 16'sd1, 16'sd0, 1'b1, 16'sh7fff, 16'sh8000, ST_SAT},
    // Truncation toward zero on a negative quotient, and a zero result.
    '{OP_DIV, -16'sd1, 16'sd0, 16'sh7fff, 16'sd0, 1'b0, 16'sd0, 16'sd0, ST_OK},
    '{OP_DIV, 16'sd0, 16'sd0, 16'sh8000, 16'sh8000, 1'b1, 16'sd0, 16'sd0, ST_OK},
    '{OP_DIV, 16'sd100, -16'sd300, -16'sd7, 16'sd3, 1'b0, 16'sd0, 16'sd0, ST_OK},
    '{OP_DIV, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0, 16'sd0, 16'sd0, ST_OK},
    '{OP_DIV, 16'sh7fff, 16'sd1, 16'sh8000, -16'sd1, 1'b0, 16'sd0, 16'sd0, ST_OK}
  };

  initial begin
    cplx_res_t row_res;
    int idle_set[4];
    int stall_set[4];
    errors = 0;
    cycles = 0;
    items_sent = 0;
    results_seen = 0;
    sat_seen = 0;
    dz_seen = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = OP_ADD;
    in_a_real = '0;
    in_a_imag = '0;
    in_b_real = '0;
    in_b_imag = '0;
    out_stall = 1'b0;
    // Phases: free flow, a lazy sender, a slow receiver, then both at once.
    idle_set  = '{0, 65, 0, 29};
    stall_set = '{0, 0, 65, 29};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].typed) begin
        row_res.re = dir_rows[i].er;
        row_res.im = dir_rows[i].ei;
        row_res.st = dir_rows[i].est;
      end else begin
        row_res = predict_cplx(dir_rows[i].op, dir_rows[i].ar, dir_rows[i].ai,
                               dir_rows[i].br, dir_rows[i].bi);
      end
      send_item(dir_rows[i].op, dir_rows[i].ar, dir_rows[i].ai,
                dir_rows[i].br, dir_rows[i].bi, row_res);
    end

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_set[p];
      stall_pct = stall_set[p];
      for (int n = 0; n < RAND_PER_PHASE; n++) send_random();
    end
    in_valid <= 1'b0;

    // Drain, then give any stray result time to show up.
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);

    $display("Sent %0d items over four handshake phases; %0d results checked,",
             items_sent, results_seen);
    $display("%0d of them saturated and %0d divide-by-zero.", sat_seen, dz_seen);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
